[rtl/qvr_pkg.sv]
// Shared types, widths and saturation helpers for the quaternion vector rotation block.
package qvr_pkg;

	localparam int QUAT_FRAC_BITS = 14;
	localparam int VEC_WIDTH      = 16;

	localparam int QUAT_W  = QUAT_FRAC_BITS + 2;
	localparam int PROD_W  = 2 * QUAT_W;
	localparam int DIAG_W  = PROD_W + 2;
	localparam int OFF_W   = PROD_W + 1;
	localparam int TRND_W  = QUAT_FRAC_BITS + 6;
	localparam int MV_W    = QUAT_W + VEC_WIDTH;
	localparam int MSUM_W  = MV_W + 2;
	localparam int ORND_W  = VEC_WIDTH + 4;

	localparam int NUM_STAGES = 6;

	localparam logic signed [DIAG_W-1:0] DIAG_HALF = DIAG_W'(1) <<< (QUAT_FRAC_BITS - 1);
	localparam logic signed [OFF_W-1:0]  OFF_HALF  = OFF_W'(1) <<< (QUAT_FRAC_BITS - 2);
	localparam logic signed [MSUM_W-1:0] OUT_HALF  = MSUM_W'(1) <<< (QUAT_FRAC_BITS - 1);

	localparam logic signed [TRND_W-1:0] TERM_MAX =
		{{(TRND_W - QUAT_W + 1){1'b0}}, {(QUAT_W - 1){1'b1}}};
	localparam logic signed [TRND_W-1:0] TERM_MIN =
		{{(TRND_W - QUAT_W + 1){1'b1}}, {(QUAT_W - 1){1'b0}}};
	localparam logic signed [ORND_W-1:0] OUT_MAX =
		{{(ORND_W - VEC_WIDTH + 1){1'b0}}, {(VEC_WIDTH - 1){1'b1}}};
	localparam logic signed [ORND_W-1:0] OUT_MIN =
		{{(ORND_W - VEC_WIDTH + 1){1'b1}}, {(VEC_WIDTH - 1){1'b0}}};

	typedef struct packed {
		logic                    operation;
		logic signed [QUAT_W-1:0] quat_w;
		logic signed [QUAT_W-1:0] quat_x;
		logic signed [QUAT_W-1:0] quat_y;
		logic signed [QUAT_W-1:0] quat_z;
		logic signed [VEC_WIDTH-1:0] vec_x;
		logic signed [VEC_WIDTH-1:0] vec_y;
		logic signed [VEC_WIDTH-1:0] vec_z;
	} in_t;

	typedef struct packed {
		logic signed [VEC_WIDTH-1:0] out_x;
		logic signed [VEC_WIDTH-1:0] out_y;
		logic signed [VEC_WIDTH-1:0] out_z;
		logic                       clipped;
	} out_t;

	typedef struct packed {
		logic signed [VEC_WIDTH-1:0] x;
		logic signed [VEC_WIDTH-1:0] y;
		logic signed [VEC_WIDTH-1:0] z;
	} vec_t;

	typedef logic [2:0][2:0][QUAT_W-1:0] mat_t;

	typedef struct packed {
		logic [NUM_STAGES-1:0] load;
	} pipe_ctl_t;

	function automatic logic signed [QUAT_W-1:0] sat_term(input logic signed [TRND_W-1:0] a);
		logic signed [QUAT_W-1:0] r;
		if (a > TERM_MAX) begin
			r = TERM_MAX[QUAT_W-1:0];
		end else if (a < TERM_MIN) begin
			r = TERM_MIN[QUAT_W-1:0];
		end else begin
			r = a[QUAT_W-1:0];
		end
		return r;
	endfunction

	function automatic logic signed [VEC_WIDTH-1:0] sat_out(input logic signed [ORND_W-1:0] a);
		logic signed [VEC_WIDTH-1:0] r;
		if (a > OUT_MAX) begin
			r = OUT_MAX[VEC_WIDTH-1:0];
		end else if (a < OUT_MIN) begin
			r = OUT_MIN[VEC_WIDTH-1:0];
		end else begin
			r = a[VEC_WIDTH-1:0];
		end
		return r;
	endfunction

	function automatic logic out_ovf(input logic signed [ORND_W-1:0] a);
		return (a > OUT_MAX) || (a < OUT_MIN);
	endfunction

endpackage

[rtl/qvr_pipe_ctrl.sv]
// Pipeline valid bits and per-stage ready chain for the rotation datapath.
module qvr_pipe_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output qvr_pkg::pipe_ctl_t  ctl
);

	logic [qvr_pkg::NUM_STAGES-1:0] valid_q;
	logic [qvr_pkg::NUM_STAGES-1:0] rdy;

	always_comb begin
		rdy[qvr_pkg::NUM_STAGES-1] = !valid_q[qvr_pkg::NUM_STAGES-1] || out_ready;
		for (int k = qvr_pkg::NUM_STAGES - 2; k >= 0; k--) begin
			rdy[k] = !valid_q[k] || rdy[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (rdy[0]) begin
				valid_q[0] <= in_valid;
			end
			for (int k = 1; k < qvr_pkg::NUM_STAGES; k++) begin
				if (rdy[k]) begin
					valid_q[k] <= valid_q[k-1];
				end
			end
		end
	end

	assign ctl.load  = rdy;
	assign in_ready  = rdy[0];
	assign out_valid = valid_q[qvr_pkg::NUM_STAGES-1];

	// A ready sink keeps the whole pipeline flowing.
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("pipeline blocked while output is ready");

	// An accepted transaction always lands in the first stage.
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> valid_q[0])
		else $error("accepted transaction lost at first stage");

	// A stalled result at the output is kept, not dropped.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("stalled result dropped");

	// An empty stage never refuses new data.
	a_bubble: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_q[0] |-> ctl.load[0])
		else $error("empty first stage not loading");

endmodule

[rtl/qvr_matrix.sv]
// Rotation matrix build: quaternion products, term sums, rounding, saturation and transpose.
module qvr_matrix (
	input  logic               clk,
	input  qvr_pkg::pipe_ctl_t ctl,
	input  qvr_pkg::in_t       in_data,
	output qvr_pkg::mat_t      mat_s3,
	output qvr_pkg::vec_t      vec_s3
);

	logic signed [qvr_pkg::PROD_W-1:0] ww_s1, xx_s1, yy_s1, zz_s1;
	logic signed [qvr_pkg::PROD_W-1:0] xy_s1, xz_s1, yz_s1, wx_s1, wy_s1, wz_s1;
	logic                              op_s1, op_s2;
	qvr_pkg::vec_t                     vec_s1, vec_s2;

	logic signed [qvr_pkg::DIAG_W-1:0] diag_s2 [3];
	logic signed [qvr_pkg::OFF_W-1:0]  off_s2 [6];

	logic signed [qvr_pkg::QUAT_W-1:0] m_c [3][3];

	always_ff @(posedge clk) begin
		if (ctl.load[0]) begin
			ww_s1  <= in_data.quat_w * in_data.quat_w;
			xx_s1  <= in_data.quat_x * in_data.quat_x;
			yy_s1  <= in_data.quat_y * in_data.quat_y;
			zz_s1  <= in_data.quat_z * in_data.quat_z;
			xy_s1  <= in_data.quat_x * in_data.quat_y;
			xz_s1  <= in_data.quat_x * in_data.quat_z;
			yz_s1  <= in_data.quat_y * in_data.quat_z;
			wx_s1  <= in_data.quat_w * in_data.quat_x;
			wy_s1  <= in_data.quat_w * in_data.quat_y;
			wz_s1  <= in_data.quat_w * in_data.quat_z;
			op_s1  <= in_data.operation;
			vec_s1 <= '{x: in_data.vec_x, y: in_data.vec_y, z: in_data.vec_z};
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load[1]) begin
			diag_s2[0] <= qvr_pkg::DIAG_W'(ww_s1) + qvr_pkg::DIAG_W'(xx_s1)
				- qvr_pkg::DIAG_W'(yy_s1) - qvr_pkg::DIAG_W'(zz_s1) + qvr_pkg::DIAG_HALF;
			diag_s2[1] <= qvr_pkg::DIAG_W'(ww_s1) - qvr_pkg::DIAG_W'(xx_s1)
				+ qvr_pkg::DIAG_W'(yy_s1) - qvr_pkg::DIAG_W'(zz_s1) + qvr_pkg::DIAG_HALF;
			diag_s2[2] <= qvr_pkg::DIAG_W'(ww_s1) - qvr_pkg::DIAG_W'(xx_s1)
				- qvr_pkg::DIAG_W'(yy_s1) + qvr_pkg::DIAG_W'(zz_s1) + qvr_pkg::DIAG_HALF;
			off_s2[0]  <= qvr_pkg::OFF_W'(xy_s1) - qvr_pkg::OFF_W'(wz_s1) + qvr_pkg::OFF_HALF;
			off_s2[1]  <= qvr_pkg::OFF_W'(xz_s1) + qvr_pkg::OFF_W'(wy_s1) + qvr_pkg::OFF_HALF;
			off_s2[2]  <= qvr_pkg::OFF_W'(xy_s1) + qvr_pkg::OFF_W'(wz_s1) + qvr_pkg::OFF_HALF;
			off_s2[3]  <= qvr_pkg::OFF_W'(yz_s1) - qvr_pkg::OFF_W'(wx_s1) + qvr_pkg::OFF_HALF;
			off_s2[4]  <= qvr_pkg::OFF_W'(xz_s1) - qvr_pkg::OFF_W'(wy_s1) + qvr_pkg::OFF_HALF;
			off_s2[5]  <= qvr_pkg::OFF_W'(yz_s1) + qvr_pkg::OFF_W'(wx_s1) + qvr_pkg::OFF_HALF;
			op_s2      <= op_s1;
			vec_s2     <= vec_s1;
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			m_c[i][i] = qvr_pkg::sat_term(
				qvr_pkg::TRND_W'(diag_s2[i] >>> qvr_pkg::QUAT_FRAC_BITS));
		end
		m_c[0][1] = qvr_pkg::sat_term(
			qvr_pkg::TRND_W'(off_s2[0] >>> (qvr_pkg::QUAT_FRAC_BITS - 1)));
		m_c[0][2] = qvr_pkg::sat_term(
			qvr_pkg::TRND_W'(off_s2[1] >>> (qvr_pkg::QUAT_FRAC_BITS - 1)));
		m_c[1][0] = qvr_pkg::sat_term(
			qvr_pkg::TRND_W'(off_s2[2] >>> (qvr_pkg::QUAT_FRAC_BITS - 1)));
		m_c[1][2] = qvr_pkg::sat_term(
			qvr_pkg::TRND_W'(off_s2[3] >>> (qvr_pkg::QUAT_FRAC_BITS - 1)));
		m_c[2][0] = qvr_pkg::sat_term(
			qvr_pkg::TRND_W'(off_s2[4] >>> (qvr_pkg::QUAT_FRAC_BITS - 1)));
		m_c[2][1] = qvr_pkg::sat_term(
			qvr_pkg::TRND_W'(off_s2[5] >>> (qvr_pkg::QUAT_FRAC_BITS - 1)));
	end

	// Navigation to body uses the transposed matrix.
	always_ff @(posedge clk) begin
		if (ctl.load[2]) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					mat_s3[i][j] <= op_s2 ? m_c[i][j] : m_c[j][i];
				end
			end
			vec_s3 <= vec_s2;
		end
	end

endmodule

[rtl/qvr_mat_vec.sv]
// Matrix times vector: term products, row sums, rounding, saturation and clip flag.
module qvr_mat_vec (
	input  logic               clk,
	input  qvr_pkg::pipe_ctl_t ctl,
	input  qvr_pkg::mat_t      mat_s3,
	input  qvr_pkg::vec_t      vec_s3,
	output qvr_pkg::out_t      out_s6
);

	logic signed [qvr_pkg::VEC_WIDTH-1:0] v_c [3];
	logic signed [qvr_pkg::MV_W-1:0]      prod_s4 [3][3];
	logic signed [qvr_pkg::MSUM_W-1:0]    sum_s5 [3];
	logic signed [qvr_pkg::ORND_W-1:0]    rnd_c [3];

	assign v_c[0] = vec_s3.x;
	assign v_c[1] = vec_s3.y;
	assign v_c[2] = vec_s3.z;

	always_ff @(posedge clk) begin
		if (ctl.load[3]) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					prod_s4[i][j] <= $signed(mat_s3[i][j]) * v_c[j];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load[4]) begin
			for (int i = 0; i < 3; i++) begin
				sum_s5[i] <= qvr_pkg::MSUM_W'(prod_s4[i][0]) + qvr_pkg::MSUM_W'(prod_s4[i][1])
					+ qvr_pkg::MSUM_W'(prod_s4[i][2]) + qvr_pkg::OUT_HALF;
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rnd_c[i] = qvr_pkg::ORND_W'(sum_s5[i] >>> qvr_pkg::QUAT_FRAC_BITS);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load[5]) begin
			out_s6.out_x   <= qvr_pkg::sat_out(rnd_c[0]);
			out_s6.out_y   <= qvr_pkg::sat_out(rnd_c[1]);
			out_s6.out_z   <= qvr_pkg::sat_out(rnd_c[2]);
			out_s6.clipped <= qvr_pkg::out_ovf(rnd_c[0]) || qvr_pkg::out_ovf(rnd_c[1])
				|| qvr_pkg::out_ovf(rnd_c[2]);
		end
	end

endmodule

[rtl/quaternion_vector_rotation.sv]
// Top level of the quaternion vector rotation pipeline.
// Throughput: one transaction per cycle while out_ready is high, set by the
// six-stage pipeline with one multiplier bank per product stage; an output
// stall holds each full stage that has no empty stage after it.
// Reset clears only the stage valid bits; datapath registers are not reset.
module quaternion_vector_rotation (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  qvr_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output qvr_pkg::out_t out_data
);

	qvr_pkg::pipe_ctl_t ctl;
	qvr_pkg::mat_t      mat_s3;
	qvr_pkg::vec_t      vec_s3;

	qvr_pipe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.ctl       (ctl)
	);

	qvr_matrix u_matrix (
		.clk     (clk),
		.ctl     (ctl),
		.in_data (in_data),
		.mat_s3  (mat_s3),
		.vec_s3  (vec_s3)
	);

	qvr_mat_vec u_mat_vec (
		.clk    (clk),
		.ctl    (ctl),
		.mat_s3 (mat_s3),
		.vec_s3 (vec_s3),
		.out_s6 (out_data)
	);

endmodule
